@@ sv/dst_pkg.sv @@
// ----------------------------------------------------------------------------
// dst_pkg
// Shared types and constants for the delimiter set tokenizer.
// ----------------------------------------------------------------------------
package dst_pkg;

  // longest string position tracked, positions saturate at the lesser of
  // this and the 16-bit offset range
  localparam int unsigned MAX_STRING_LEN = 32'd65535;
  localparam int unsigned POS_W          = 16;
  localparam logic [POS_W-1:0] POS_BOUND =
    (MAX_STRING_LEN > 32'd65535) ? 16'hFFFF : 16'(MAX_STRING_LEN);

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned SET_W    = 64;
  localparam int unsigned CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_SET_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_SET_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_SET_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_SET_3 = 3'd3;

  // byte class handed from the front to the back
  typedef enum logic [1:0] {
    CLS_TEXT  = 2'd0,
    CLS_DELIM = 2'd1,
    CLS_TERM  = 2'd2
  } char_cls_t;

  typedef struct packed {
    char_cls_t cls;
  } cls_item_t;

  // queue handshake between front and back
  typedef struct packed {
    logic      valid;
    cls_item_t item;
  } cls_push_t;

  typedef struct packed {
    logic      valid;
    cls_item_t item;
  } cls_head_t;

endpackage

@@ sv/delimiter_set_tokenizer_top.sv @@
// ----------------------------------------------------------------------------
// delimiter_set_tokenizer_top
// Splits a zero-terminated byte stream into tokens against a 256-entry
// delimiter set.
//
//   channel  direction  handshake             payload
//   cfg      in         cfg_valid/cfg_ready   cfg_index[2:0], cfg_data[63:0]
//   in       in         in_valid/in_ready     in_char_byte[7:0]
//   out      out        out_valid/out_ready   token_start, token_length,
//                                             token_found, string_done
//
// one byte per cycle sustained while out_ready holds, the rate set by the
// back-stage scanner, one class per cycle; each class waits in a two-entry
// queue, then its result is registered; the queue lets the front keep taking
// bytes while the result register is stalled; in_ready drops only when full
// synchronous reset clears the delimiter set, the queue and the scan state
// ----------------------------------------------------------------------------
module delimiter_set_tokenizer_top
  import dst_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SET_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CHAR_W-1:0]    in_char_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [POS_W-1:0]     out_token_start,
  output logic [POS_W-1:0]     out_token_length,
  output logic                 out_token_found,
  output logic                 out_string_done
);

  cls_push_t push;
  cls_head_t head;
  logic      q_full;
  logic      pop;

  dst_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_byte (in_char_byte),
    .q_full       (q_full),
    .push         (push)
  );

  dst_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (head),
    .pop   (pop)
  );

  dst_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_token_found  (out_token_found),
    .out_string_done  (out_string_done)
  );

endmodule

@@ sv/dst_front.sv @@
// ----------------------------------------------------------------------------
// dst_front
// Holds the delimiter set and classifies each accepted byte.
// ----------------------------------------------------------------------------
module dst_front
  import dst_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SET_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CHAR_W-1:0]    in_char_byte,
  input  logic                 q_full,
  output cls_push_t            push
);

  logic [SET_W-1:0] set0_r, set1_r, set2_r, set3_r;
  logic [SET_W-1:0] word;
  logic             is_delim;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set0_r <= '0;
      set1_r <= '0;
      set2_r <= '0;
      set3_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DELIM_SET_0: set0_r <= cfg_data;
        REG_DELIM_SET_1: set1_r <= cfg_data;
        REG_DELIM_SET_2: set2_r <= cfg_data;
        REG_DELIM_SET_3: set3_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (in_char_byte[7:6])
      2'd0:    word = set0_r;
      2'd1:    word = set1_r;
      2'd2:    word = set2_r;
      default: word = set3_r;
    endcase
    is_delim = word[in_char_byte[5:0]];
  end

  assign in_ready = !q_full;

  always_comb begin
    push.valid = in_valid && !q_full;
    if (in_char_byte == '0) begin
      push.item.cls = CLS_TERM;
    end else if (is_delim) begin
      push.item.cls = CLS_DELIM;
    end else begin
      push.item.cls = CLS_TEXT;
    end
  end

endmodule

@@ sv/dst_queue.sv @@
// ----------------------------------------------------------------------------
// dst_queue
// Two-entry queue of byte classes between front and back.
// ----------------------------------------------------------------------------
module dst_queue
  import dst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cls_push_t push,
  output logic      full,
  output cls_head_t head,
  input  logic      pop
);

  cls_item_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign full       = (cnt_r == 2'd2);
  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push.valid) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (do_pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    case ({push.valid, do_pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.item;
    end
  end

endmodule

@@ sv/dst_back.sv @@
// ----------------------------------------------------------------------------
// dst_back
// Token scanner: tracks position and open token, drives the result register.
// ----------------------------------------------------------------------------
module dst_back
  import dst_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cls_head_t        head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [POS_W-1:0] out_token_start,
  output logic [POS_W-1:0] out_token_length,
  output logic             out_token_found,
  output logic             out_string_done
);

  logic             inside_r, inside_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] start_r, start_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic [POS_W-1:0] ostart_r, ostart_nxt;
  logic [POS_W-1:0] olen_r, olen_nxt;
  logic             ofound_r, ofound_nxt;
  logic             odone_r, odone_nxt;
  logic             emit;
  logic [POS_W-1:0] pos_inc;

  assign pop     = head.valid && (!ovalid_r || out_ready);
  assign pos_inc = (pos_r < POS_BOUND) ? pos_r + 1'b1 : pos_r;

  always_comb begin
    inside_nxt = inside_r;
    pos_nxt    = pos_r;
    start_nxt  = start_r;
    emit       = 1'b0;
    ostart_nxt = ostart_r;
    olen_nxt   = olen_r;
    ofound_nxt = ofound_r;
    odone_nxt  = odone_r;
    if (pop) begin
      unique case (head.item.cls)
        CLS_TERM: begin
          emit       = 1'b1;
          ofound_nxt = inside_r;
          odone_nxt  = 1'b1;
          ostart_nxt = inside_r ? start_r : '0;
          olen_nxt   = inside_r ? pos_r - start_r : '0;
          inside_nxt = 1'b0;
          pos_nxt    = '0;
          start_nxt  = '0;
        end
        CLS_DELIM: begin
          if (inside_r) begin
            emit       = 1'b1;
            ofound_nxt = 1'b1;
            odone_nxt  = 1'b0;
            ostart_nxt = start_r;
            olen_nxt   = pos_r - start_r;
          end
          inside_nxt = 1'b0;
          pos_nxt    = pos_inc;
        end
        default: begin
          if (!inside_r) begin
            inside_nxt = 1'b1;
            start_nxt  = pos_r;
          end
          pos_nxt = pos_inc;
        end
      endcase
    end
    if (emit) begin
      ovalid_nxt = 1'b1;
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end else begin
      ovalid_nxt = ovalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      pos_r    <= '0;
      start_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      inside_r <= inside_nxt;
      pos_r    <= pos_nxt;
      start_r  <= start_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ostart_r <= ostart_nxt;
    olen_r   <= olen_nxt;
    ofound_r <= ofound_nxt;
    odone_r  <= odone_nxt;
  end

  assign out_valid        = ovalid_r;
  assign out_token_start  = ostart_r;
  assign out_token_length = olen_r;
  assign out_token_found  = ofound_r;
  assign out_string_done  = odone_r;

endmodule

@@ sv/dst_checker.sv @@
// ----------------------------------------------------------------------------
// dst_checker
// Port-level checks on the tokenizer's result channel.
// ----------------------------------------------------------------------------
module dst_checker
  import dst_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [POS_W-1:0]     out_token_start,
  input logic [POS_W-1:0]     out_token_length,
  input logic                 out_token_found,
  input logic                 out_string_done
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // no result comes out of the cycle after a reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // only the terminator may give a result without a token
  a_token_or_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_token_found || out_string_done))
    else $error("empty result that is not a string end");

  // an empty string end carries zero offset and length
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_token_found |-> (out_token_start == '0) && (out_token_length == '0))
    else $error("empty result with nonzero fields");

endmodule

bind delimiter_set_tokenizer_top dst_checker u_dst_checker (.*);
